>>> rtl/pprm_pkg.sv
`default_nettype none

package pprm_pkg;

  // Fixed field widths of the stream and register words
  localparam int RMS_W   = 16;
  localparam int PEAK_W  = 16;
  localparam int TOTAL_W = 32;
  localparam int THR_W   = 16;
  localparam int KIND_W  = 2;
  localparam int SUM_W   = 64;

  // Defaults for the top-level parameters
  localparam int SAMPLE_W_DEF = 16;
  localparam int COUNT_W_DEF  = 32;

  // Iterative units: one quotient bit, then one root bit, per cycle
  localparam int DIV_STEPS  = SUM_W;
  localparam int ROOT_STEPS = SUM_W / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [SUM_W-1:0] ROOT_PROBE_INIT = {2'b01, {(SUM_W - 2){1'b0}}};
  localparam logic [RMS_W-1:0] RMS_MAX         = '1;

  // Word kinds on the input stream
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

  // Configuration register map
  localparam int        APB_ADDR_W    = 3;
  localparam logic      REG_THRESHOLD = 1'b0;

  typedef struct packed {
    logic add_en;
    logic clear_en;
    logic div_load;
    logic div_step;
    logic root_load;
    logic root_step;
    logic out_write;
  } cmd_t;

  typedef struct packed {
    logic step_last;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/pprm_ctrl.sv
`default_nettype none

module pprm_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  input  wire logic [pprm_pkg::KIND_W-1:0] kind,
  output logic                             s_tready,
  input  wire logic                        m_tready,
  output logic                             m_tvalid,
  input  wire pprm_pkg::stat_t             stat,
  output pprm_pkg::cmd_t                   cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_DIV   = 6'b000100,
    S_RLOAD = 6'b001000,
    S_ROOT  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;
  logic   in_fire;
  logic   slot_free;

  assign s_tready  = (state == S_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign slot_free = !out_valid || m_tready;
  assign m_tvalid  = out_valid;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.add_en   = in_fire && (kind == pprm_pkg::KIND_ADD);
        cmd.clear_en = in_fire && (kind == pprm_pkg::KIND_CLEAR);
        if (in_fire && (kind == pprm_pkg::KIND_REPORT)) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.step_last) begin
          state_next = S_RLOAD;
        end
      end
      S_RLOAD: begin
        cmd.root_load = 1'b1;
        state_next    = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (stat.step_last) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.out_write = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_write) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // A report word always starts with the load cycle
  a_report_loads: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (kind == pprm_pkg::KIND_REPORT)) |=> (state == S_LOAD))
    else $error("report word did not start the divider");

  // The square root runs only after a complete division
  a_root_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_RLOAD) |-> ($past(state) == S_DIV) && $past(stat.step_last))
    else $error("root loaded before the quotient was finished");

  // A new result appears only out of the output state
  a_out_from_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> ($past(state) == S_OUT))
    else $error("result word raised outside the output state");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && !m_tready) |=> (state == S_OUT))
    else $error("output state left while the result was stalled");

endmodule

`default_nettype wire

>>> rtl/pprm_dpath.sv
`default_nettype none

module pprm_dpath #(
  parameter int SAMPLE_W = pprm_pkg::SAMPLE_W_DEF,
  parameter int COUNT_W  = pprm_pkg::COUNT_W_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire pprm_pkg::cmd_t               cmd,
  output pprm_pkg::stat_t                   stat,
  input  wire logic [SAMPLE_W-1:0]          sample,
  input  wire logic [pprm_pkg::THR_W-1:0]   threshold,
  output logic      [pprm_pkg::RMS_W-1:0]   rms_level,
  output logic      [pprm_pkg::PEAK_W-1:0]  peak_level,
  output logic      [pprm_pkg::TOTAL_W-1:0] sample_total,
  output logic                              is_silent
);

  localparam int SUM_W = pprm_pkg::SUM_W;
  localparam int SQ_W  = 2 * SAMPLE_W;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Running metrics
  logic [SAMPLE_W-1:0] peak;
  logic [SUM_W-1:0]    sum;
  logic [COUNT_W-1:0]  count;

  // Square pipeline stage ahead of the accumulator
  logic [SQ_W-1:0]     square;
  logic                square_valid;
  logic [SAMPLE_W-1:0] mag;

  // Divider
  logic [COUNT_W-1:0]  div_rem;
  logic [SUM_W-1:0]    quo;
  logic [COUNT_W:0]    div_trial;
  logic [COUNT_W:0]    div_diff;
  logic                div_ge;

  // Square root
  logic [SUM_W-1:0]    root_rem;
  logic [SUM_W-1:0]    root_acc;
  logic [SUM_W-1:0]    probe;
  logic [SUM_W-1:0]    root_trial;
  logic                root_ge;

  logic [pprm_pkg::STEP_W-1:0] step_cnt;
  logic [pprm_pkg::RMS_W-1:0]  rms_sat;

  // -32768 negates to itself, which reads as 32768 unsigned
  assign mag = sample[SAMPLE_W-1] ? (~sample + SAMPLE_W'(1)) : sample;

  assign div_trial = {div_rem, quo[SUM_W-1]};
  assign div_ge    = (div_trial >= {1'b0, count});
  assign div_diff  = div_trial - {1'b0, count};

  assign root_trial = root_acc + probe;
  assign root_ge    = (root_rem >= root_trial);

  assign stat.step_last = (step_cnt == '0);

  always_comb begin
    if (count == '0) begin
      rms_sat = '0;
    end else if (root_acc > SUM_W'(pprm_pkg::RMS_MAX)) begin
      rms_sat = pprm_pkg::RMS_MAX;
    end else begin
      rms_sat = pprm_pkg::RMS_W'(root_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak         <= '0;
      sum          <= '0;
      count        <= '0;
      square_valid <= 1'b0;
    end else if (cmd.clear_en) begin
      peak         <= '0;
      sum          <= '0;
      count        <= '0;
      square_valid <= 1'b0;
    end else begin
      if (square_valid) begin
        sum <= sum + SUM_W'(square);
      end
      square_valid <= cmd.add_en;
      if (cmd.add_en) begin
        if (mag > peak) begin
          peak <= mag;
        end
        if (count != COUNT_MAX) begin
          count <= count + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_en) begin
      square <= SQ_W'(mag) * SQ_W'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_rem  <= '0;
      quo      <= sum;
      step_cnt <= pprm_pkg::STEP_W'(pprm_pkg::DIV_STEPS - 1);
    end else if (cmd.div_step) begin
      div_rem  <= div_ge ? div_diff[COUNT_W-1:0] : div_trial[COUNT_W-1:0];
      quo      <= {quo[SUM_W-2:0], div_ge};
      step_cnt <= step_cnt - pprm_pkg::STEP_W'(1);
    end else if (cmd.root_load) begin
      step_cnt <= pprm_pkg::STEP_W'(pprm_pkg::ROOT_STEPS - 1);
    end else if (cmd.root_step) begin
      step_cnt <= step_cnt - pprm_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_load) begin
      root_rem <= quo;
      root_acc <= '0;
      probe    <= pprm_pkg::ROOT_PROBE_INIT;
    end else if (cmd.root_step) begin
      if (root_ge) begin
        root_rem <= root_rem - root_trial;
        root_acc <= (root_acc >> 1) + probe;
      end else begin
        root_acc <= root_acc >> 1;
      end
      probe <= probe >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_write) begin
      rms_level    <= rms_sat;
      peak_level   <= pprm_pkg::PEAK_W'(peak);
      sample_total <= pprm_pkg::TOTAL_W'(count);
      is_silent    <= (rms_sat < threshold);
    end
  end

endmodule

`default_nettype wire

>>> rtl/pcm_peak_rms_meter.sv
// PCM peak and RMS level meter.
// Input stream (s_*): one word per item. s_tuser carries the kind: add a
// sample, clear the metrics, or report them; s_tdata carries the signed
// sample, used by add words only. Kind code 3 is dropped.
// Output stream (m_*): one word per report, with the RMS level, the peak
// magnitude, the saturating sample count and the silence flag in m_tuser.
// Add and clear words, taken one per cycle while idle, give no output word.
// A report runs a load step, the divider (one quotient bit of sum/count per
// cycle), a root load step and the square root (one root bit per cycle),
// then writes the output register; m_tvalid rises and the next input word
// can be taken in the cycle after that write. s_tready stays low meanwhile.
// A stalled receiver holds the result in the output register while adds
// and clears keep flowing; a following report waits in its output state.
// The silence threshold is set over the APB port at address 0.
// Reset (synchronous, active high) zeroes peak, sum, count and threshold.
`default_nettype none

module pcm_peak_rms_meter #(
  parameter int SAMPLE_W = pprm_pkg::SAMPLE_W_DEF,
  parameter int COUNT_W  = pprm_pkg::COUNT_W_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [((SAMPLE_W + 7) / 8)*8-1:0] s_tdata,  // sample
  input  wire logic [pprm_pkg::KIND_W-1:0]       s_tuser,  // kind
  // Output stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [63:0]                            m_tdata,  // rms_level, peak_level, sample_total
  output logic [0:0]                             m_tuser,  // is_silent
  // Configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pprm_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  pprm_pkg::cmd_t  cmd;
  pprm_pkg::stat_t stat;

  logic [pprm_pkg::THR_W-1:0]   threshold;
  logic [pprm_pkg::RMS_W-1:0]   rms_level;
  logic [pprm_pkg::PEAK_W-1:0]  peak_level;
  logic [pprm_pkg::TOTAL_W-1:0] sample_total;
  logic                         is_silent;
  logic                         reg_hit;

  // Registers sit on word addresses; bit 2 picks the register
  assign reg_hit = (paddr[2] == pprm_pkg::REG_THRESHOLD);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      threshold <= pwdata[pprm_pkg::THR_W-1:0];
    end
  end

  // Read back the threshold; unmapped addresses read zero
  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = 32'(threshold);
    end
  end

  pprm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .kind     (s_tuser),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .stat     (stat),
    .cmd      (cmd)
  );

  pprm_dpath #(
    .SAMPLE_W (SAMPLE_W),
    .COUNT_W  (COUNT_W)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample       (s_tdata[SAMPLE_W-1:0]),
    .threshold    (threshold),
    .rms_level    (rms_level),
    .peak_level   (peak_level),
    .sample_total (sample_total),
    .is_silent    (is_silent)
  );

  // Pack the result word, first field in the low bits
  assign m_tdata = {sample_total, peak_level, rms_level};
  assign m_tuser = is_silent;

endmodule

`default_nettype wire
